// ----- rtl/core/lmss_pkg.sv -----
// Package for the LED matrix scroll scanner: field widths, codes, item and
// result structs, and the built-in glyph tables. No dependencies.
package lmss_pkg;

  localparam int MATRIX_ROWS = 8;
  localparam int ROW_W       = $clog2(MATRIX_ROWS);
  localparam int PIX_W       = 8;
  localparam int SLOT_W      = 5;
  localparam int PERIOD_W    = 16;
  localparam int FLOOR_W     = 3;
  localparam int CFG_DATA_W  = PERIOD_W;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET    = 16'd500;
  localparam logic [PERIOD_W-1:0] ELAPSED_MAX     = 16'hFFFF;
  localparam logic [SLOT_W-1:0]   LAST_SLOT_RESET = 5'd4;
  localparam logic [FLOOR_W-1:0]  FLOOR_MAX       = 3'd4;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    MODE_STOP = 2'd0,
    MODE_UP   = 2'd1,
    MODE_DOWN = 2'd2,
    MODE_IDLE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_BLANK = 2'd0,
    KIND_UP    = 2'd1,
    KIND_DOWN  = 2'd2
  } kind_t;

  typedef enum logic {
    CFG_SCROLL_PERIOD = 1'b0,
    CFG_LAST_SLOT     = 1'b1
  } cfg_index_t;

  typedef struct packed {
    op_t                 opcode;
    mode_t               mode;
    logic [FLOOR_W-1:0]  floor_number;
  } item_t;

  typedef struct packed {
    logic [PIX_W-1:0] column_select;
    logic [PIX_W-1:0] row_pixels;
    logic [ROW_W-1:0] row_number;
  } result_t;

  typedef logic [PIX_W-1:0] glyph_t [MATRIX_ROWS];

  localparam glyph_t DIGIT_GLYPH [5] = '{
    '{8'h18, 8'h3E, 8'h42, 8'h42, 8'h42, 8'h42, 8'h7E, 8'h18},
    '{8'h00, 8'h18, 8'h38, 8'h78, 8'h18, 8'h18, 8'h7E, 8'h00},
    '{8'h00, 8'h3C, 8'h66, 8'h46, 8'h0C, 8'h18, 8'h7E, 8'h00},
    '{8'h00, 8'h3C, 8'h42, 8'h02, 8'h0E, 8'h42, 8'h3C, 8'h00},
    '{8'h00, 8'h0C, 8'h14, 8'h24, 8'h7E, 8'h04, 8'h04, 8'h00}
  };
  localparam glyph_t UP_GLYPH   = '{8'h18, 8'h3C, 8'h7E, 8'hFF, 8'h3C, 8'h3C, 8'h3C, 8'h00};
  localparam glyph_t DOWN_GLYPH = '{8'h00, 8'h3C, 8'h3C, 8'h3C, 8'hFF, 8'h7E, 8'h3C, 8'h18};

  // Floor digits above four show as four.
  function automatic logic [FLOOR_W-1:0] sat_floor(input logic [FLOOR_W-1:0] f);
    return (f > FLOOR_MAX) ? FLOOR_MAX : f;
  endfunction

  function automatic logic [PIX_W-1:0] digit_row(input logic [FLOOR_W-1:0] f,
                                                 input logic [ROW_W-1:0] r);
    logic [FLOOR_W-1:0] fs;
    fs = sat_floor(f);
    return DIGIT_GLYPH[fs][r];
  endfunction

  // One row of a scroll slot: blank, arrow, six slots of the digit, then blank.
  function automatic logic [PIX_W-1:0] slot_row(input kind_t kind,
                                                input logic [FLOOR_W-1:0] f,
                                                input logic [SLOT_W-1:0] slot,
                                                input logic [ROW_W-1:0] r);
    logic [PIX_W-1:0] arrow;
    logic [PIX_W-1:0] pix;
    arrow = (kind == KIND_UP) ? UP_GLYPH[r] : DOWN_GLYPH[r];
    pix   = '0;
    if (kind == KIND_UP || kind == KIND_DOWN) begin
      if (slot == 5'd1) begin
        pix = arrow;
      end else if (slot >= 5'd2 && slot <= 5'd7) begin
        pix = digit_row(f, r);
      end
    end
    return pix;
  endfunction

endpackage

// ----- rtl/core/led_matrix_scroll_scanner_core.sv -----
// Top level of the LED matrix scroll scanner: input register, frame and
// scroll state, output register. Depends on lmss_pkg, lmss_cfg, lmss_frame.
//
// Usage. Items arrive on the s_ stream channel. A beat with s_tuser low is a
// one millisecond tick; with s_tuser high it loads new scroll content (stop,
// up or down, plus a floor digit). Loads and ticks in mode three give no
// result; every other tick gives one beat on the m_ channel carrying the
// active-low column select, the pixel bits and the index of the row driven.
// The configuration port sets the scroll period in ticks and the last slot
// before the scroll sequence wraps; write it only while the block is idle.
//
// Timing. An accepted beat lands in the input register; once it fires, its
// state update and row lookup are done in one step and the result is
// captured in the output register, which then raises m_tvalid. One item
// per cycle is taken in steady state while the receiver does not stall,
// since the whole update is combinational between the input register and
// the output register.
//
// Reset (synchronous, rst high) clears the frame to blank, the row, offset,
// slot and time counters to zero and restores the default configuration.
// When the receiver stalls, the result waits in the output register; one more
// item may enter the input register, and items that give no result pass on.
module led_matrix_scroll_scanner_core
  import lmss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [1:0] mode, [4:2] floor_number
  input  logic                  s_tuser,   // [0] opcode
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata,   // [7:0] column_select, [15:8] row_pixels,
                                           // [18:16] row_number
  input  logic                  cfg_we,
  input  cfg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                in_valid;
  item_t               in_item;
  logic                fire;
  logic                has_result;
  result_t             result;
  result_t             out_result;
  logic [PERIOD_W-1:0] scroll_period;
  logic [SLOT_W-1:0]   last_slot;

  lmss_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .scroll_period (scroll_period),
    .last_slot     (last_slot)
  );

  lmss_frame u_frame (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .item          (in_item),
    .scroll_period (scroll_period),
    .last_slot     (last_slot),
    .has_result    (has_result),
    .result        (result)
  );

  // The held item is processed when its result, if any, has a free slot:
  // the output register is empty or is being emptied in this cycle.
  assign fire     = in_valid && (!has_result || !m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.opcode       <= op_t'(s_tuser);
      in_item.mode         <= mode_t'(s_tdata[1:0]);
      in_item.floor_number <= s_tdata[4:2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && has_result) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_result) begin
      out_result <= result;
    end
  end

  assign m_tdata = {5'd0, out_result.row_number, out_result.row_pixels,
                    out_result.column_select};

  // The column select always matches the row number it is sent with.
  a_select_matches_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:0] == ~(8'd1 << m_tdata[18:16])))
    else $error("column select does not match row number");

endmodule

// ----- rtl/core/lmss_cfg.sv -----
// Configuration registers of the LED matrix scroll scanner: scroll period
// and last slot index. Depends on lmss_pkg.
module lmss_cfg
  import lmss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  cfg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [PERIOD_W-1:0]   scroll_period,
  output logic [SLOT_W-1:0]     last_slot
);

  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_period <= PERIOD_RESET;
      last_slot     <= LAST_SLOT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCROLL_PERIOD: scroll_period <= cfg_data[PERIOD_W-1:0];
        CFG_LAST_SLOT:     last_slot     <= cfg_data[SLOT_W-1:0];
      endcase
    end
  end

endmodule

// ----- rtl/core/lmss_frame.sv -----
// Frame and scroll state of the LED matrix scroll scanner. Works out the
// next state and the driven row for one registered item. Depends on lmss_pkg.
module lmss_frame
  import lmss_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  item_t               item,
  input  logic [PERIOD_W-1:0] scroll_period,
  input  logic [SLOT_W-1:0]   last_slot,
  output logic                has_result,
  output result_t             result
);

  logic [PIX_W-1:0]    frame_rows [MATRIX_ROWS];
  logic [PIX_W-1:0]    frame_rows_next [MATRIX_ROWS];
  logic [ROW_W-1:0]    scan_row, scan_row_next;
  logic [ROW_W-1:0]    scroll_offset, scroll_offset_next;
  logic [SLOT_W-1:0]   slot_index, slot_index_next;
  logic [PERIOD_W-1:0] elapsed_ms, elapsed_ms_next;
  kind_t               content_kind, content_kind_next;
  logic [FLOOR_W-1:0]  content_floor, content_floor_next;

  logic                is_tick;
  logic                moving;
  logic                step;
  logic [FLOOR_W-1:0]  floor_sat;
  logic [PERIOD_W-1:0] elapsed_inc;

  assign is_tick     = (item.opcode == OP_TICK);
  assign moving      = (item.mode == MODE_UP) || (item.mode == MODE_DOWN);
  assign floor_sat   = sat_floor(item.floor_number);
  assign elapsed_inc = (elapsed_ms == ELAPSED_MAX) ? elapsed_ms : elapsed_ms + 16'd1;
  assign step        = is_tick && moving && (elapsed_inc >= scroll_period);
  assign has_result  = is_tick && (item.mode != MODE_IDLE);

  always_comb begin
    frame_rows_next    = frame_rows;
    content_kind_next  = content_kind;
    content_floor_next = content_floor;
    elapsed_ms_next    = elapsed_ms;
    scroll_offset_next = scroll_offset;
    slot_index_next    = slot_index;
    scan_row_next      = scan_row;
    if (!is_tick) begin
      content_floor_next = floor_sat;
      unique case (item.mode)
        MODE_STOP: begin
          content_kind_next = KIND_BLANK;
          for (int i = 0; i < MATRIX_ROWS; i++) begin
            frame_rows_next[i] = digit_row(floor_sat, ROW_W'(i));
          end
        end
        MODE_UP: begin
          content_kind_next = KIND_UP;
          frame_rows_next   = UP_GLYPH;
        end
        MODE_DOWN: begin
          content_kind_next = KIND_DOWN;
          frame_rows_next   = DOWN_GLYPH;
        end
        MODE_IDLE: begin
          content_kind_next = KIND_BLANK;
        end
      endcase
    end else begin
      elapsed_ms_next = step ? '0 : elapsed_inc;
      if (item.mode == MODE_STOP) begin
        content_kind_next  = KIND_BLANK;
        content_floor_next = floor_sat;
        for (int i = 0; i < MATRIX_ROWS; i++) begin
          frame_rows_next[i] = digit_row(floor_sat, ROW_W'(i));
        end
      end
      if (step) begin
        // Up reads glyph row i + offset, down reads row i - offset, both mod 8.
        for (int i = 0; i < MATRIX_ROWS; i++) begin
          frame_rows_next[i] = slot_row(content_kind, content_floor, slot_index,
                                        (item.mode == MODE_UP) ?
                                        ROW_W'(i) + scroll_offset :
                                        ROW_W'(i) - scroll_offset);
        end
        scroll_offset_next = scroll_offset + 3'd1;
        if (scroll_offset == ROW_W'(MATRIX_ROWS - 1)) begin
          slot_index_next = (slot_index == last_slot) ? '0 : slot_index + 5'd1;
        end
      end
      if (has_result) begin
        scan_row_next = scan_row + 3'd1;
      end
    end
  end

  assign result.column_select = ~(PIX_W'(1) << scan_row);
  assign result.row_pixels    = frame_rows_next[scan_row];
  assign result.row_number    = scan_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MATRIX_ROWS; i++) begin
        frame_rows[i] <= '0;
      end
      scan_row      <= '0;
      scroll_offset <= '0;
      slot_index    <= '0;
      elapsed_ms    <= '0;
      content_kind  <= KIND_BLANK;
      content_floor <= '0;
    end else if (fire) begin
      frame_rows    <= frame_rows_next;
      scan_row      <= scan_row_next;
      scroll_offset <= scroll_offset_next;
      slot_index    <= slot_index_next;
      elapsed_ms    <= elapsed_ms_next;
      content_kind  <= content_kind_next;
      content_floor <= content_floor_next;
    end
  end

  // The scanned row moves only when a row is actually driven.
  a_scan_hold: assert property (@(posedge clk) disable iff (rst)
    !(fire && has_result) |=> $stable(scan_row))
    else $error("scan row moved without a driven row");

  // A scroll step always restarts the millisecond count.
  a_step_restarts: assert property (@(posedge clk) disable iff (rst)
    (scroll_offset != $past(scroll_offset)) |-> (elapsed_ms == '0))
    else $error("scroll offset moved without restarting the period");

endmodule
